// ===== hdl/ods_pkg.sv =====
`default_nettype none
package ods_pkg;

	localparam int RATE_W  = 32;
	localparam int XTAL_W  = 47;
	localparam int DCO_W   = 35;
	localparam int PROD_W  = 43;
	localparam int MULT_W  = 11;
	localparam int FRAC_SH = 48;
	localparam int QUO_W   = 38;
	localparam int DIV_STEPS = DCO_W + FRAC_SH;
	localparam int CNT_W   = $clog2(DIV_STEPS + 1);

	localparam logic [RATE_W-1:0] RATE_MIN = 32'd10000000;
	localparam logic [RATE_W-1:0] BAND1_LO = 32'd945000000;
	localparam logic [RATE_W-1:0] BAND1_HI = 32'd970000000;
	localparam logic [RATE_W-1:0] BAND2_LO = 32'd1134000000;
	localparam logic [RATE_W-1:0] BAND2_HI = 32'd1212500000;
	localparam logic [DCO_W-1:0]  DCO_MIN  = 35'd4850000000;
	localparam logic [DCO_W-1:0]  DCO_MAX  = 35'd5670000000;

	localparam logic [XTAL_W-1:0] XTAL_RST = 47'd119836508160000;
	localparam logic [RATE_W-1:0] MAX_RST  = 32'd1400000000;

	localparam logic [6:0] N_LAST  = 7'd64;
	localparam logic [2:0] HS_LAST = 3'd5;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_ADJ   = 2'd1;
	localparam logic [1:0] STAT_NODIV = 2'd2;

	localparam logic REG_XTAL = 1'b0;
	localparam logic REG_MAX  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADJUST,
		ST_SEARCH,
		ST_DRAIN,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	function automatic logic [3:0] hs_value(input logic [2:0] idx);
		logic [3:0] v;
		case (idx)
			3'd0:    v = 4'd4;
			3'd1:    v = 4'd5;
			3'd2:    v = 4'd6;
			3'd3:    v = 4'd7;
			3'd4:    v = 4'd9;
			3'd5:    v = 4'd11;
			default: v = 4'd4;
		endcase
		return v;
	endfunction

	function automatic logic [2:0] hs_code(input logic [2:0] idx);
		logic [3:0] v;
		v = hs_value(idx) - 4'd4;
		return v[2:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/ods_rfreq_div.sv =====
`default_nettype none
module ods_rfreq_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire logic [ods_pkg::DCO_W-1:0]     dco,
	input  wire logic [ods_pkg::XTAL_W-1:0]    xtal,
	output logic                               done,
	output logic [ods_pkg::QUO_W-1:0]          quo
);

	logic                              run_q;
	logic                              done_q;
	logic [ods_pkg::CNT_W-1:0]         cnt_q;
	logic [ods_pkg::DCO_W-1:0]         num_q;
	logic [ods_pkg::XTAL_W-1:0]        rem_q;
	logic [ods_pkg::QUO_W-1:0]         quo_q;
	logic [ods_pkg::XTAL_W:0]          rem_sh;
	logic [ods_pkg::XTAL_W:0]          rem_sub;
	logic                              ge;

	assign rem_sh  = {rem_q, num_q[ods_pkg::DCO_W-1]};
	assign ge      = rem_sh >= {1'b0, xtal};
	assign rem_sub = rem_sh - {1'b0, xtal};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == ods_pkg::CNT_W'(1));
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= ods_pkg::CNT_W'(ods_pkg::DIV_STEPS);
			end else if (run_q) begin
				cnt_q <= cnt_q - ods_pkg::CNT_W'(1);
				if (cnt_q == ods_pkg::CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			num_q <= dco;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[ods_pkg::DCO_W-2:0], 1'b0};
			rem_q <= ge ? rem_sub[ods_pkg::XTAL_W-1:0] : rem_sh[ods_pkg::XTAL_W-1:0];
			quo_q <= {quo_q[ods_pkg::QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

// ===== hdl/oscillator_divider_search_core.sv =====
`default_nettype none
// Channel   Handshake                  Payload
// input     start, busy                target_rate_hz
// result    done (one-cycle strobe)    used_rate_hz, status, six register bytes
// config    APB: psel/penable/pwrite   paddr[3] selects register, pwdata, prdata
//
// An item first adjusts the rate, then runs the divider search through one 32x11
// multiplier and a compare stage, then a pipeline drain, then an 83-step
// restoring division for RFREQ, one quotient bit a cycle.
// Items with a fixed divider skip the search.
// busy stays high from acceptance through the done cycle. Reset loads the
// register defaults. The receiver cannot stall; done lasts one cycle.
module oscillator_divider_search_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] target_rate_hz,
	output logic             done,
	output logic [31:0]      used_rate_hz,
	output logic [1:0]       status,
	output logic [7:0]       hsdiv_n1_byte,
	output logic [7:0]       n1_rfreq_byte,
	output logic [7:0]       rfreq_byte_hi,
	output logic [7:0]       rfreq_byte_mid_hi,
	output logic [7:0]       rfreq_byte_mid_lo,
	output logic [7:0]       rfreq_byte_lo,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	ods_pkg::state_t state_q, state_d;

	logic [ods_pkg::XTAL_W-1:0] xtal_q;
	logic [ods_pkg::RATE_W-1:0] max_q;
	logic [ods_pkg::RATE_W-1:0] rate_q;
	logic [1:0]                 status_q;

	logic [6:0] n_cnt_q;
	logic [2:0] h_cnt_q;

	logic                        v_s1, force_s1;
	logic [2:0]                  hs_s1;
	logic [6:0]                  n_s1;
	logic [ods_pkg::MULT_W-1:0]  m_s1;
	logic                        v_s2, force_s2;
	logic [2:0]                  hs_s2;
	logic [6:0]                  n_s2;
	logic [ods_pkg::PROD_W-1:0]  dco_s2;

	logic [ods_pkg::DCO_W-1:0] best_q;
	logic [2:0]                best_hs_q;
	logic [6:0]                best_n_q;
	logic                      found_q;

	logic [ods_pkg::RATE_W-1:0] adj_rate;
	logic [1:0]                 adj_status;
	logic                       fixed_div;
	logic                       search_last;
	logic                       drain_empty;
	logic                       take;

	logic       issue_v, issue_force;
	logic [2:0] issue_hs;
	logic [6:0] issue_n;
	logic [7:0] issue_nval;
	logic [11:0] issue_m;

	logic                       div_load;
	logic                       div_done;
	logic [ods_pkg::QUO_W-1:0]  quo;
	logic [6:0]                 n1_code;
	logic [2:0]                 hs_cd;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign prdata = (paddr[3] == ods_pkg::REG_MAX) ? {32'b0, max_q} : {17'b0, xtal_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xtal_q <= ods_pkg::XTAL_RST;
			max_q  <= ods_pkg::MAX_RST;
		end else if (wr_en) begin
			if (paddr[3] == ods_pkg::REG_MAX) begin
				max_q <= pwdata[31:0];
			end else begin
				xtal_q <= pwdata[ods_pkg::XTAL_W-1:0];
			end
		end
	end

	always_comb begin
		adj_rate   = (rate_q > max_q) ? max_q : rate_q;
		adj_status = ods_pkg::STAT_OK;
		if (adj_rate < ods_pkg::RATE_MIN) begin
			adj_rate   = ods_pkg::RATE_MIN;
			adj_status = ods_pkg::STAT_ADJ;
		end
		if (adj_rate > ods_pkg::BAND1_LO && adj_rate < ods_pkg::BAND1_HI) begin
			adj_rate   = ods_pkg::BAND1_LO;
			adj_status = ods_pkg::STAT_ADJ;
		end
		if (adj_rate > ods_pkg::BAND2_LO && adj_rate < ods_pkg::BAND2_HI) begin
			adj_rate   = ods_pkg::BAND2_LO;
			adj_status = ods_pkg::STAT_ADJ;
		end
	end

	assign fixed_div   = adj_rate >= ods_pkg::BAND1_HI;
	assign search_last = (n_cnt_q == ods_pkg::N_LAST) && (h_cnt_q == ods_pkg::HS_LAST);
	assign drain_empty = !v_s1 && !v_s2;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ods_pkg::ST_IDLE:   if (start) state_d = ods_pkg::ST_ADJUST;
			ods_pkg::ST_ADJUST: state_d = fixed_div ? ods_pkg::ST_DRAIN : ods_pkg::ST_SEARCH;
			ods_pkg::ST_SEARCH: if (search_last) state_d = ods_pkg::ST_DRAIN;
			ods_pkg::ST_DRAIN: begin
				if (drain_empty) begin
					state_d = found_q ? ods_pkg::ST_DIVIDE : ods_pkg::ST_DONE;
				end
			end
			ods_pkg::ST_DIVIDE: if (div_done) state_d = ods_pkg::ST_DONE;
			ods_pkg::ST_DONE:   state_d = ods_pkg::ST_IDLE;
			default:            state_d = ods_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy        = state_q != ods_pkg::ST_IDLE;
		done        = state_q == ods_pkg::ST_DONE;
		issue_v     = 1'b0;
		issue_force = 1'b0;
		issue_hs    = h_cnt_q;
		issue_n     = n_cnt_q;
		div_load    = (state_q == ods_pkg::ST_DRAIN) && drain_empty && found_q;
		case (state_q)
			ods_pkg::ST_ADJUST: begin
				if (fixed_div) begin
					issue_v     = 1'b1;
					issue_force = 1'b1;
					issue_hs    = (adj_rate >= ods_pkg::BAND2_HI) ? 3'd0 : 3'd1;
					issue_n     = 7'd0;
				end
			end
			ods_pkg::ST_SEARCH: issue_v = 1'b1;
			default:            issue_v = 1'b0;
		endcase
	end

	assign issue_nval = (issue_n == 7'd0) ? 8'd1 : {issue_n, 1'b0};
	assign issue_m    = 12'(ods_pkg::hs_value(issue_hs)) * 12'(issue_nval);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ods_pkg::ST_IDLE;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue_v;
			v_s2    <= v_s1;
			if (state_q == ods_pkg::ST_ADJUST) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	assign take = v_s2 && (force_s2 ||
		(dco_s2 >= ods_pkg::PROD_W'(ods_pkg::DCO_MIN) &&
		 dco_s2 <= ods_pkg::PROD_W'(best_q)));

	always_ff @(posedge clk) begin
		if (state_q == ods_pkg::ST_IDLE && start) begin
			rate_q <= target_rate_hz;
		end
		if (state_q == ods_pkg::ST_ADJUST) begin
			rate_q   <= adj_rate;
			status_q <= adj_status;
			n_cnt_q  <= 7'd0;
			h_cnt_q  <= 3'd0;
			best_q   <= ods_pkg::DCO_MAX;
		end else begin
			if (state_q == ods_pkg::ST_SEARCH) begin
				if (h_cnt_q == ods_pkg::HS_LAST) begin
					h_cnt_q <= 3'd0;
					n_cnt_q <= n_cnt_q + 7'd1;
				end else begin
					h_cnt_q <= h_cnt_q + 3'd1;
				end
			end
			if (take) begin
				best_q    <= dco_s2[ods_pkg::DCO_W-1:0];
				best_hs_q <= hs_s2;
				best_n_q  <= n_s2;
			end
			if (state_q == ods_pkg::ST_DRAIN && drain_empty && !found_q) begin
				status_q <= ods_pkg::STAT_NODIV;
			end
		end
		force_s1 <= issue_force;
		hs_s1    <= issue_hs;
		n_s1     <= issue_n;
		m_s1     <= issue_m[ods_pkg::MULT_W-1:0];
		force_s2 <= force_s1;
		hs_s2    <= hs_s1;
		n_s2     <= n_s1;
		dco_s2   <= ods_pkg::PROD_W'(rate_q) * ods_pkg::PROD_W'(m_s1);
	end

	ods_rfreq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (div_load),
		.dco    (best_q),
		.xtal   (xtal_q),
		.done   (div_done),
		.quo    (quo)
	);

	assign n1_code = (best_n_q == 7'd0) ? 7'd0 : {6'(best_n_q - 7'd1), 1'b1};
	assign hs_cd   = ods_pkg::hs_code(best_hs_q);

	assign used_rate_hz      = rate_q;
	assign status            = status_q;
	assign hsdiv_n1_byte     = found_q ? {hs_cd, n1_code[6:2]} : 8'd0;
	assign n1_rfreq_byte     = found_q ? {n1_code[1:0], quo[37:32]} : 8'd0;
	assign rfreq_byte_hi     = found_q ? quo[31:24] : 8'd0;
	assign rfreq_byte_mid_hi = found_q ? quo[23:16] : 8'd0;
	assign rfreq_byte_mid_lo = found_q ? quo[15:8] : 8'd0;
	assign rfreq_byte_lo     = found_q ? quo[7:0] : 8'd0;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;

	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 20;
	localparam logic [23:0] HS_SET = {4'd11, 4'd9, 4'd7, 4'd6, 4'd5, 4'd4};

	typedef struct packed {
		logic [31:0] used_rate;
		logic [1:0]  status;
		logic [7:0]  hsdiv_n1;
		logic [7:0]  n1_rfreq;
		logic [7:0]  rf_hi;
		logic [7:0]  rf_mid_hi;
		logic [7:0]  rf_mid_lo;
		logic [7:0]  rf_lo;
	} rate_plan_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] target_rate_hz;
	logic        done;
	logic [31:0] used_rate_hz;
	logic [1:0]  status;
	logic [7:0]  hsdiv_n1_byte;
	logic [7:0]  n1_rfreq_byte;
	logic [7:0]  rfreq_byte_hi;
	logic [7:0]  rfreq_byte_mid_hi;
	logic [7:0]  rfreq_byte_mid_lo;
	logic [7:0]  rfreq_byte_lo;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	logic [46:0] xtal_q20;
	logic [31:0] max_rate;
	rate_plan_t  plan_q[$];
	rate_plan_t  want;
	int          err_cnt;
	int          stall_cycles;
	bit          burst;

	oscillator_divider_search_core u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.target_rate_hz    (target_rate_hz),
		.done              (done),
		.used_rate_hz      (used_rate_hz),
		.status            (status),
		.hsdiv_n1_byte     (hsdiv_n1_byte),
		.n1_rfreq_byte     (n1_rfreq_byte),
		.rfreq_byte_hi     (rfreq_byte_hi),
		.rfreq_byte_mid_hi (rfreq_byte_mid_hi),
		.rfreq_byte_mid_lo (rfreq_byte_mid_lo),
		.rfreq_byte_lo     (rfreq_byte_lo),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic rate_plan_t plan_rate(input logic [31:0] target, input logic [46:0] xtal,
			input logic [31:0] rate_cap);
		rate_plan_t   p;
		logic [63:0]  rate;
		logic [63:0]  best;
		logic [63:0]  dco;
		logic [63:0]  hs;
		logic [63:0]  n1;
		logic [63:0]  hs_try;
		logic         found;
		logic [127:0] quo;
		logic [37:0]  rf;
		logic [2:0]   hs_bits;
		logic [6:0]   n1_bits;
		logic [63:0]  n;
		int           j;
		p = '0;
		p.status = ods_pkg::STAT_OK;
		rate = {32'b0, target};
		if (rate > {32'b0, rate_cap})
			rate = {32'b0, rate_cap};
		if (rate < {32'b0, ods_pkg::RATE_MIN}) begin
			rate = {32'b0, ods_pkg::RATE_MIN};
			p.status = ods_pkg::STAT_ADJ;
		end
		if (rate > {32'b0, ods_pkg::BAND1_LO} && rate < {32'b0, ods_pkg::BAND1_HI}) begin
			rate = {32'b0, ods_pkg::BAND1_LO};
			p.status = ods_pkg::STAT_ADJ;
		end
		if (rate > {32'b0, ods_pkg::BAND2_LO} && rate < {32'b0, ods_pkg::BAND2_HI}) begin
			rate = {32'b0, ods_pkg::BAND2_LO};
			p.status = ods_pkg::STAT_ADJ;
		end
		p.used_rate = rate[31:0];
		hs = '0;
		n1 = '0;
		found = 1'b0;
		if (rate >= {32'b0, ods_pkg::BAND2_HI}) begin
			hs = 64'd4;
			n1 = 64'd1;
			found = 1'b1;
		end else if (rate >= {32'b0, ods_pkg::BAND1_HI}) begin
			hs = 64'd5;
			n1 = 64'd1;
			found = 1'b1;
		end else begin
			best = {29'b0, ods_pkg::DCO_MAX};
			n = 64'd1;
			while (n <= 64'd128) begin
				for (j = 0; j < 6; j++) begin
					hs_try = {60'b0, HS_SET[4*j +: 4]};
					dco = rate * hs_try * n;
					if (dco >= {29'b0, ods_pkg::DCO_MIN} && dco <= best) begin
						best = dco;
						hs = hs_try;
						n1 = n;
						found = 1'b1;
					end
				end
				n = (n == 64'd1) ? 64'd2 : n + 64'd2;
			end
		end
		if (!found) begin
			p.status = ods_pkg::STAT_NODIV;
			return p;
		end
		dco = rate * hs * n1;
		if (xtal == '0)
			rf = '1;
		else begin
			quo = ({64'b0, dco} << 48) / {81'b0, xtal};
			rf = quo[37:0];
		end
		hs_bits = hs[2:0] - 3'd4;
		n1_bits = n1[6:0] - 7'd1;
		p.hsdiv_n1 = {hs_bits, n1_bits[6:2]};
		p.n1_rfreq = {n1_bits[1:0], rf[37:32]};
		p.rf_hi = rf[31:24];
		p.rf_mid_hi = rf[23:16];
		p.rf_mid_lo = rf[15:8];
		p.rf_lo = rf[7:0];
		return p;
	endfunction

	function automatic logic [31:0] pick_rate();
		logic [31:0] edge_rate;
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom;
			3, 4, 5, 6: return $urandom_range(945000000, 10000000);
			7: begin
				case ($urandom_range(0, 6))
					0: edge_rate = ods_pkg::RATE_MIN;
					1: edge_rate = ods_pkg::BAND1_LO;
					2: edge_rate = ods_pkg::BAND1_HI;
					3: edge_rate = ods_pkg::BAND2_LO;
					4: edge_rate = ods_pkg::BAND2_HI;
					5: edge_rate = 32'd808333333;
					default: edge_rate = max_rate;
				endcase
				return edge_rate + $urandom_range(0, 4) - 32'd2;
			end
			default: return $urandom_range(1500000000, 945000000);
		endcase
	endfunction

	function automatic logic [46:0] pick_xtal();
		logic [46:0] v;
		if ($urandom_range(0, 3) == 0)
			v = 47'({$urandom, $urandom});
		else
			v = ({15'b0, 32'($urandom_range(120000000, 10000000))} << 20)
				| 47'($urandom_range(1048575, 0));
		if (v == '0)
			v = 47'd1;
		return v;
	endfunction

	task automatic report_error(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		err_cnt++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] exp_v);
		if (got !== exp_v)
			report_error($sformatf("%s got 0x%0h, want 0x%0h", name, got, exp_v));
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (plan_q.size() == 0)
				report_error($sformatf("unexpected result, used_rate_hz %0d", used_rate_hz));
			else begin
				want = plan_q.pop_front();
				check_field("used_rate_hz", used_rate_hz, want.used_rate);
				check_field("status", {30'b0, status}, {30'b0, want.status});
				check_field("hsdiv_n1_byte", {24'b0, hsdiv_n1_byte}, {24'b0, want.hsdiv_n1});
				check_field("n1_rfreq_byte", {24'b0, n1_rfreq_byte}, {24'b0, want.n1_rfreq});
				check_field("rfreq_byte_hi", {24'b0, rfreq_byte_hi}, {24'b0, want.rf_hi});
				check_field("rfreq_byte_mid_hi", {24'b0, rfreq_byte_mid_hi},
					{24'b0, want.rf_mid_hi});
				check_field("rfreq_byte_mid_lo", {24'b0, rfreq_byte_mid_lo},
					{24'b0, want.rf_mid_lo});
				check_field("rfreq_byte_lo", {24'b0, rfreq_byte_lo}, {24'b0, want.rf_lo});
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic request_rate(input logic [31:0] rate);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			while (busy)
				@(negedge clk);
			repeat (gap) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		target_rate_hz <= rate;
		do
			@(posedge clk);
		while (busy);
		plan_q.push_back(plan_rate(rate, xtal_q20, max_rate));
		@(negedge clk);
		start <= 1'b0;
		target_rate_hz <= $urandom;
	endtask

	task automatic wait_idle();
		while (plan_q.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [63:0] value);
		logic [63:0] readback;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx == ods_pkg::REG_XTAL)
			xtal_q20 = value[46:0];
		else
			max_rate = value[31:0];
		readback = (idx == ods_pkg::REG_XTAL) ? {17'b0, xtal_q20} : {32'b0, max_rate};
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		pwdata <= {$urandom, $urandom};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== readback)
			report_error($sformatf("register %0d read 0x%0h, want 0x%0h", idx, prdata, readback));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_random(input int count);
		repeat (count) request_rate(pick_rate());
	endtask

	task automatic test_reset_defaults();
		burst = 1'b0;
		request_rate(32'd0);
		request_rate(ods_pkg::RATE_MIN - 32'd1);
		request_rate(ods_pkg::RATE_MIN);
		request_rate(ods_pkg::RATE_MIN + 32'd1);
		request_rate(32'd100000000);
		request_rate(32'd808333333);
		request_rate(32'd808333334);
		request_rate(ods_pkg::BAND1_LO);
		request_rate(ods_pkg::BAND1_LO + 32'd1);
		request_rate(ods_pkg::BAND1_HI - 32'd1);
		request_rate(ods_pkg::BAND1_HI);
		request_rate(ods_pkg::BAND2_LO);
		request_rate(ods_pkg::BAND2_LO + 32'd1);
		request_rate(ods_pkg::BAND2_HI - 32'd1);
		request_rate(ods_pkg::BAND2_HI);
		request_rate(ods_pkg::MAX_RST);
		request_rate(ods_pkg::MAX_RST + 32'd1);
		request_rate(32'hFFFFFFFF);
		request_rate(32'h55555555);
		request_rate(32'h2AAAAAAA);
	endtask

	task automatic test_crystal_extremes();
		logic [46:0] xtal_set [4];
		int i;
		xtal_set[0] = 47'd1;
		xtal_set[1] = '1;
		xtal_set[2] = '0;
		xtal_set[3] = 47'd104857600000000;
		for (i = 0; i < 4; i++) begin
			wait_idle();
			write_reg(ods_pkg::REG_XTAL, {17'($urandom), xtal_set[i]});
			burst = (i % 2) == 1;
			send_random(25);
		end
	endtask

	task automatic test_rate_limit_extremes();
		logic [31:0] cap_set [4];
		int i;
		cap_set[0] = ods_pkg::RATE_MIN;
		cap_set[1] = 32'hFFFFFFFF;
		cap_set[2] = 32'd960000000;
		cap_set[3] = 32'd1200000000;
		wait_idle();
		write_reg(ods_pkg::REG_XTAL, {17'($urandom), ods_pkg::XTAL_RST});
		for (i = 0; i < 4; i++) begin
			wait_idle();
			write_reg(ods_pkg::REG_MAX, {$urandom, cap_set[i]});
			burst = (i % 2) == 0;
			send_random(25);
		end
	endtask

	task automatic test_random_traffic();
		repeat (8) begin
			wait_idle();
			write_reg(ods_pkg::REG_XTAL, {17'($urandom), pick_xtal()});
			write_reg(ods_pkg::REG_MAX, {$urandom, ($urandom_range(0, 1) == 0)
				? 32'($urandom_range(1500000000, 10000000)) : 32'($urandom_range(32'hFFFFFFFF, 10000000))});
			burst = $urandom_range(0, 3) == 0;
			send_random(125);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		target_rate_hz = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		xtal_q20 = ods_pkg::XTAL_RST;
		max_rate = ods_pkg::MAX_RST;
		err_cnt = 0;
		stall_cycles = 0;
		burst = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_crystal_extremes();
		test_rate_limit_extremes();
		test_random_traffic();
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
